>>> design/tpcal_pkg.sv
// ----------------------------------------------------------------------------
// tpcal_pkg
// Shared constants of the touch panel calibrate and map block.
// ----------------------------------------------------------------------------
package tpcal_pkg;

    localparam int RAW_W    = 16;
    localparam int SIZE_W   = 13;
    localparam int MARGIN_W = 11;
    localparam int TOL_W    = 12;
    localparam int PIX_W    = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TAP_COUNT = 5;

    // signed working width for numerators (raw * scale fits in 31 bits)
    localparam int NUM_W = 32;
    localparam int DIV_W = 32;

    localparam logic [15:0] DEF_LEFT_RAW   = 16'd200;
    localparam logic [15:0] DEF_RIGHT_RAW  = 16'd3900;
    localparam logic [15:0] DEF_TOP_RAW    = 16'd200;
    localparam logic [15:0] DEF_BOTTOM_RAW = 16'd3900;

    localparam logic [2:0] CFG_SCREEN_W = 3'd0;
    localparam logic [2:0] CFG_SCREEN_H = 3'd1;
    localparam logic [2:0] CFG_MARGIN   = 3'd2;
    localparam logic [2:0] CFG_MIN_SPAN = 3'd3;
    localparam logic [2:0] CFG_CTR_TOL  = 3'd4;

    localparam logic [1:0] OP_MAP     = 2'd0;
    localparam logic [1:0] OP_STORE   = 2'd1;
    localparam logic [1:0] OP_CAL     = 2'd2;
    localparam logic [1:0] OP_RESTORE = 2'd3;

endpackage

>>> design/tpcal_div.sv
// ----------------------------------------------------------------------------
// tpcal_div
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tpcal_div
    import tpcal_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] num,
    input  logic signed [DIV_W-1:0] den,
    output logic                    done,
    output logic signed [DIV_W-1:0] quo
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [DIV_W:0]   r_reg, r_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; neg_next = neg_reg;
        busy_next = busy_reg; cnt_next = cnt_reg; done_next = 1'b0;
        trial = {r_reg[DIV_W-1:0], q_reg[DIV_W-1]} - {1'b0, d_reg};
        if (start) begin
            q_next = num[DIV_W-1] ? DIV_W'(-num) : num;
            d_next = den[DIV_W-1] ? DIV_W'(-den) : den;
            neg_next = num[DIV_W-1] ^ den[DIV_W-1];
            r_next = '0;
            cnt_next = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_W]) begin
                r_next = trial;
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[DIV_W-1:0], q_reg[DIV_W-1]};
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? DIV_W'(-q_reg) : q_reg;
endmodule

>>> design/touch_panel_calibrate_and_map.sv
// ----------------------------------------------------------------------------
// touch_panel_calibrate_and_map
// Linear touch calibration: map raw readings, store taps, calibrate, restore.
// ----------------------------------------------------------------------------
// Sequencing: a map runs two serial divides (x, then y), store and restore go
//   straight to the output state, calibrate runs four divides, or none when the
//   span or usable-area check rejects up front.
// Throughput: one item at a time; the next accept is possible once the result is
//   registered (held off while the output register is full); the pace is set by the 32-step bit-serial divider.
// Reset: synchronous active low; edges and registers take defaults, taps stay
//   undefined until stored.
module touch_panel_calibrate_and_map
    import tpcal_pkg::*;
#(
    parameter logic [15:0] DEFAULT_LEFT_RAW   = DEF_LEFT_RAW,
    parameter logic [15:0] DEFAULT_RIGHT_RAW  = DEF_RIGHT_RAW,
    parameter logic [15:0] DEFAULT_TOP_RAW    = DEF_TOP_RAW,
    parameter logic [15:0] DEFAULT_BOTTOM_RAW = DEF_BOTTOM_RAW
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // opcode[1:0], tap_slot[4:2], raw_x[20:5], raw_y[36:21]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // screen_x[11:0], screen_y[23:12], status[24]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_MAPX, S_MAPY, S_CAL_A, S_CAL_B, S_CAL_C, S_CAL_D,
        S_CAL_CX, S_CAL_CY, S_CHECK, S_OUT
    } state_t;

    state_t state_reg;
    logic [SIZE_W-1:0]   sw_reg, sh_reg;
    logic [MARGIN_W-1:0] mg_reg;
    logic [RAW_W-1:0]    ms_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic [RAW_W-1:0]    le_reg, re_reg, te_reg, be_reg;
    logic [31:0]         tap_mem [TAP_COUNT];
    logic [RAW_W-1:0]    rx_reg, ry_reg;
    logic [PIX_W-1:0]    ox_reg, oy_reg;
    logic                ost_reg, mv_reg;
    logic [2*PIX_W:0]    res_reg;
    // candidate edges and averages
    logic [RAW_W-1:0]    hlo_reg, hhi_reg, vlo_reg, vhi_reg;
    logic [RAW_W-1:0]    nl_reg, nr_reg, nt_reg, nb_reg;
    logic [RAW_W-1:0]    cxr_reg, cyr_reg;
    logic [PIX_W:0]      cx_reg;
    logic                start_reg, start_next;
    logic                cal_started;
    logic                cal_bad;

    logic signed [DIV_W-1:0] dnum, dden, dquo;
    logic                    ddone;

    tpcal_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .num(dnum), .den(dden), .done(ddone), .quo(dquo)
    );

    // map operand set for a given raw/edges/size
    function automatic logic signed [DIV_W-1:0] map_num(
        input logic [RAW_W-1:0] raw, input logic [RAW_W-1:0] lo, input logic [SIZE_W-1:0] sz);
        logic signed [17:0] d;
        logic signed [13:0] s;
        logic signed [31:0] p;
        begin
            d = $signed({2'b00, raw}) - $signed({2'b00, lo});
            s = $signed({1'b0, sz}) - 14'sd1;
            p = 32'(d * s);
            return p;
        end
    endfunction

    function automatic logic [PIX_W:0] clamp_pix(
        input logic signed [DIV_W-1:0] q, input logic [SIZE_W-1:0] sz, input logic zero);
        logic signed [DIV_W-1:0] top;
        logic signed [DIV_W-1:0] v;
        begin
            top = (sz == '0) ? '0 : $signed(DIV_W'(sz)) - 1;
            v = zero ? '0 : q;
            if (v < 0) v = '0;
            if (v > top) v = top;
            return (PIX_W+1)'(v);
        end
    endfunction

    function automatic logic [RAW_W-1:0] clamp_edge(input logic signed [DIV_W-1:0] v);
        if (v < 0) return '0;
        if (v > 32'sd65535) return 16'hFFFF;
        return v[RAW_W-1:0];
    endfunction

    // floor of the mean of two unsigned 16-bit taps
    function automatic logic [RAW_W-1:0] avg2(input logic [RAW_W-1:0] a, input logic [RAW_W-1:0] b);
        logic [RAW_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[RAW_W:1];
        end
    endfunction

    logic signed [17:0] hspan, vspan;
    logic signed [14:0] uw, uh;
    assign hspan = $signed({2'b00, hhi_reg}) - $signed({2'b00, hlo_reg});
    assign vspan = $signed({2'b00, vhi_reg}) - $signed({2'b00, vlo_reg});
    assign uw = $signed({2'b00, sw_reg}) - 15'sd1 - $signed({3'b000, mg_reg, 1'b0});
    assign uh = $signed({2'b00, sh_reg}) - 15'sd1 - $signed({3'b000, mg_reg, 1'b0});
    assign cal_bad = hspan < $signed({2'b00, ms_reg}) || vspan < $signed({2'b00, ms_reg})
                     || uw <= 0 || uh <= 0;

    // divider operand select
    always_comb begin
        dnum = '0; dden = 32'sd1;
        case (state_reg)
            S_MAPX: begin
                dnum = map_num(rx_reg, le_reg, sw_reg);
                dden = DIV_W'($signed({2'b00, re_reg}) - $signed({2'b00, le_reg}));
            end
            S_MAPY: begin
                dnum = map_num(ry_reg, te_reg, sh_reg);
                dden = DIV_W'($signed({2'b00, be_reg}) - $signed({2'b00, te_reg}));
            end
            S_CAL_A, S_CAL_B: begin
                dnum = DIV_W'(hspan * $signed({1'b0, mg_reg}));
                dden = DIV_W'(uw);
            end
            S_CAL_C, S_CAL_D: begin
                dnum = DIV_W'(vspan * $signed({1'b0, mg_reg}));
                dden = DIV_W'(uh);
            end
            S_CAL_CX: begin
                dnum = map_num(cxr_reg, nl_reg, sw_reg);
                dden = DIV_W'($signed({2'b00, nr_reg}) - $signed({2'b00, nl_reg}));
            end
            S_CAL_CY: begin
                dnum = map_num(cyr_reg, nt_reg, sh_reg);
                dden = DIV_W'($signed({2'b00, nb_reg}) - $signed({2'b00, nt_reg}));
            end
            default: ;
        endcase
    end

    logic [PIX_W:0]  pix;
    logic [PIX_W:0]  ex, ey, dxa, dya;
    logic [PIX_W:0]  cy_pix;
    assign pix = clamp_pix(dquo, (state_reg == S_MAPX || state_reg == S_CAL_CX) ? sw_reg : sh_reg,
                           dden == '0);
    assign cy_pix = pix;
    // (size - 1) / 2 truncates to 0 for a size of 0
    assign ex = (sw_reg == '0) ? '0 : (PIX_W+1)'(({1'b0, sw_reg} - 14'd1) >> 1);
    assign ey = (sh_reg == '0) ? '0 : (PIX_W+1)'(({1'b0, sh_reg} - 14'd1) >> 1);
    assign dxa = (cx_reg > ex) ? cx_reg - ex : ex - cx_reg;
    assign dya = (cy_pix > ey) ? cy_pix - ey : ey - cy_pix;

    logic [31:0] t0, t1, t2, t3, t4;
    assign t0 = tap_mem[0]; assign t1 = tap_mem[1]; assign t2 = tap_mem[2];
    assign t3 = tap_mem[3]; assign t4 = tap_mem[4];

    logic [1:0]  op;
    logic [2:0]  slot;
    assign op = s_tdata[1:0];
    assign slot = s_tdata[4:2];

    assign s_tready = (state_reg == S_IDLE) && aresetn;

    // divider kick: first divide of a map or calibrate, then one per finished divide but the last
    always_comb begin
        start_next = 1'b0;
        case (state_reg)
            S_IDLE:                    start_next = s_tvalid && s_tready && (op == OP_MAP);
            S_MAPX, S_CAL_C, S_CAL_CX: start_next = ddone;
            S_CAL_A:                   start_next = ddone ||
                                                    (!start_reg && !cal_started && !cal_bad);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg <= 1'b0;
            start_reg <= 1'b0;
            cal_started <= 1'b0;
            sw_reg <= 13'd320; sh_reg <= 13'd240; mg_reg <= 11'd20;
            ms_reg <= 16'd100; tol_reg <= 12'd20;
            le_reg <= DEFAULT_LEFT_RAW; re_reg <= DEFAULT_RIGHT_RAW;
            te_reg <= DEFAULT_TOP_RAW;  be_reg <= DEFAULT_BOTTOM_RAW;
        end else begin
            start_reg <= start_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCREEN_W: sw_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_SCREEN_H: sh_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_MARGIN:   mg_reg  <= cfg_data[MARGIN_W-1:0];
                    CFG_MIN_SPAN: ms_reg  <= cfg_data;
                    CFG_CTR_TOL:  tol_reg <= cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            // output register frees the datapath while a result waits
            if (state_reg == S_OUT && (!mv_reg || m_tready)) begin
                mv_reg  <= 1'b1;
                res_reg <= {ost_reg, oy_reg, ox_reg};
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    rx_reg <= s_tdata[20:5]; ry_reg <= s_tdata[36:21];
                    ox_reg <= '0; oy_reg <= '0; ost_reg <= 1'b0;
                    case (op)
                        OP_MAP: state_reg <= S_MAPX;
                        OP_STORE: begin
                            if (slot < 3'(TAP_COUNT))
                                tap_mem[slot] <= {s_tdata[36:21], s_tdata[20:5]};
                            state_reg <= S_OUT;
                        end
                        OP_CAL: begin
                            hlo_reg <= avg2(t0[15:0], t2[15:0]);
                            hhi_reg <= avg2(t1[15:0], t3[15:0]);
                            vlo_reg <= avg2(t0[31:16], t1[31:16]);
                            vhi_reg <= avg2(t2[31:16], t3[31:16]);
                            cxr_reg <= t4[15:0]; cyr_reg <= t4[31:16];
                            state_reg <= S_CAL_A;
                        end
                        default: begin
                            le_reg <= DEFAULT_LEFT_RAW; re_reg <= DEFAULT_RIGHT_RAW;
                            te_reg <= DEFAULT_TOP_RAW;  be_reg <= DEFAULT_BOTTOM_RAW;
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_MAPX: if (ddone) begin
                    ox_reg <= pix[PIX_W] ? '1 : pix[PIX_W-1:0];
                    state_reg <= S_MAPY;
                end
                S_MAPY: if (ddone) begin
                    oy_reg <= pix[PIX_W] ? '1 : pix[PIX_W-1:0];
                    state_reg <= S_OUT;
                end
                S_CAL_A: begin
                    if (!start_reg && !ddone && !cal_started) begin
                        if (cal_bad) begin
                            ost_reg <= 1'b1; state_reg <= S_OUT;
                        end else begin
                            cal_started <= 1'b1;
                        end
                    end else if (ddone) begin
                        nl_reg <= clamp_edge($signed({16'd0, hlo_reg}) - dquo);
                        nr_reg <= clamp_edge($signed({16'd0, hhi_reg}) + dquo);
                        state_reg <= S_CAL_C;
                    end
                end
                S_CAL_C: if (ddone) begin
                    nt_reg <= clamp_edge($signed({16'd0, vlo_reg}) - dquo);
                    nb_reg <= clamp_edge($signed({16'd0, vhi_reg}) + dquo);
                    state_reg <= S_CAL_CX;
                end
                S_CAL_CX: if (ddone) begin
                    cx_reg <= pix; state_reg <= S_CAL_CY;
                end
                S_CAL_CY: if (ddone) begin
                    cal_started <= 1'b0;
                    if (dxa > (PIX_W+1)'(tol_reg) || dya > (PIX_W+1)'(tol_reg))
                        ost_reg <= 1'b1;
                    else begin
                        le_reg <= nl_reg; re_reg <= nr_reg;
                        te_reg <= nt_reg; be_reg <= nb_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: if (!mv_reg || m_tready) begin
                    state_reg <= S_IDLE;
                    cal_started <= 1'b0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {7'd0, res_reg};
endmodule

>>> design/tpcal_checker.sv
// ----------------------------------------------------------------------------
// tpcal_checker
// Port-level checks of the touch panel calibrate and map block.
// ----------------------------------------------------------------------------
module tpcal_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // no result offered right after a reset cycle
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result valid out of reset");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:25] == 7'd0) else $error("pad bits set");
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("back to back accept");
endmodule

bind touch_panel_calibrate_and_map tpcal_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
